[design/banked_two_class_priority_queue_defines.svh]
// Assertion macros for the banked two-class priority queue.
`ifndef BANKED_TWO_CLASS_PRIORITY_QUEUE_DEFINES_SVH
`define BANKED_TWO_CLASS_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define BTPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BTPQ_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BTPQ_ASSERT(lbl, clk, rst, prop, msg)
`define BTPQ_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

[design/btpq_pkg.sv]
// Shared types and constants of the banked two-class priority queue.
`default_nettype none
package btpq_pkg;

   localparam int SEL_W      = 5;
   localparam int ENTRY_ID_W = 16;
   localparam int CODE_W     = 2;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_TAKE = 1'b1;

   localparam logic [CODE_W-1:0] RES_ADDED  = 2'd0;
   localparam logic [CODE_W-1:0] RES_FULL   = 2'd1;
   localparam logic [CODE_W-1:0] RES_SERVED = 2'd2;
   localparam logic [CODE_W-1:0] RES_EMPTY  = 2'd3;

   typedef struct packed {
      logic                  func;
      logic [SEL_W-1:0]      queue_sel;
      logic [ENTRY_ID_W-1:0] entry_id;
      logic                  urgent;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]     result_code;
      logic [ENTRY_ID_W-1:0] served_id;
      logic                  served_urgent;
   } rsp_type;

   typedef struct packed {
      logic                  func;
      logic                  in_range;
      logic [SEL_W-1:0]      queue_sel;
      logic [ENTRY_ID_W-1:0] entry_id;
      logic                  urgent;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage
`default_nettype wire

[design/btpq_fifo.sv]
// Short command queue between the front and back parts.
`default_nettype none
`include "banked_two_class_priority_queue_defines.svh"
module btpq_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire btpq_pkg::cmd_type  push_data,
   input  wire logic               pop,
   output btpq_pkg::cmd_type       pop_data,
   output btpq_pkg::fifo_status_type status
);

   btpq_pkg::cmd_type                     slot_ff [btpq_pkg::FIFO_DEPTH];
   logic [btpq_pkg::FIFO_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [btpq_pkg::FIFO_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [btpq_pkg::FIFO_CNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == btpq_pkg::FIFO_PTR_W'(btpq_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == btpq_pkg::FIFO_PTR_W'(btpq_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == btpq_pkg::FIFO_CNT_W'(btpq_pkg::FIFO_DEPTH));
   assign status.empty = (count_ff == '0);

   `BTPQ_ASSERT(a_fifo_count_bound, clock, reset,
      count_ff <= btpq_pkg::FIFO_CNT_W'(btpq_pkg::FIFO_DEPTH), "fifo count beyond depth")
   `BTPQ_ASSERT_NEVER(a_fifo_underflow, clock, reset, pop && count_ff == '0, "pop from empty fifo")
   `BTPQ_ASSERT_NEVER(a_fifo_overflow, clock, reset, push && !pop && status.full, "push into full fifo")

endmodule
`default_nettype wire

[design/btpq_front.sv]
// Front part: accepts request transactions and classifies them into commands.
`default_nettype none
module btpq_front #(
   parameter int NUM_QUEUES = 32,
   parameter int ID_WIDTH   = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire btpq_pkg::req_type          req_data,
   input  wire btpq_pkg::fifo_status_type  fifo_status,
   output logic                            push,
   output btpq_pkg::cmd_type               push_data
);

   localparam logic [btpq_pkg::ENTRY_ID_W-1:0] ID_KEEP =
      (ID_WIDTH >= btpq_pkg::ENTRY_ID_W) ? {btpq_pkg::ENTRY_ID_W{1'b1}} :
      btpq_pkg::ENTRY_ID_W'((64'd1 << ID_WIDTH) - 64'd1);

   logic              cmd_vld_ff, cmd_vld_in;
   btpq_pkg::cmd_type cmd_ff, cmd_in;
   logic              accept;

   assign req_stall = cmd_vld_ff && fifo_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = cmd_vld_ff && !fifo_status.full;
   assign push_data = cmd_ff;

   always_comb begin
      cmd_in.func      = req_data.func;
      cmd_in.in_range  = (32'(req_data.queue_sel) < NUM_QUEUES);
      cmd_in.queue_sel = req_data.queue_sel;
      cmd_in.entry_id  = req_data.entry_id & ID_KEEP;
      cmd_in.urgent    = req_data.urgent;
      cmd_vld_in = cmd_vld_ff;
      if (accept) begin
         cmd_vld_in = 1'b1;
      end else if (push) begin
         cmd_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_vld_ff <= 1'b0;
      end else begin
         cmd_vld_ff <= cmd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule
`default_nettype wire

[design/btpq_back.sv]
// Back part: read-modify-write of one queue row and the result register.
`default_nettype none
`include "banked_two_class_priority_queue_defines.svh"
module btpq_back #(
   parameter int NUM_QUEUES  = 32,
   parameter int QUEUE_DEPTH = 5,
   parameter int ID_WIDTH    = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire btpq_pkg::fifo_status_type  fifo_status,
   input  wire btpq_pkg::cmd_type          pop_data,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output btpq_pkg::rsp_type               rsp_data
);

   localparam int SW = (ID_WIDTH < btpq_pkg::ENTRY_ID_W) ? ID_WIDTH : btpq_pkg::ENTRY_ID_W;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int RW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int XW = RW + btpq_pkg::SEL_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_MOD  = 2'b10
   } state_type;

   logic [QUEUE_DEPTH-1:0][SW-1:0] mem_ids  [NUM_QUEUES];
   logic [QUEUE_DEPTH-1:0]         mem_urg  [NUM_QUEUES];
   logic [FW-1:0]                  mem_fill [NUM_QUEUES];
   logic [NUM_QUEUES-1:0]          row_vld_ff;

   state_type                      state_ff, state_in;
   btpq_pkg::cmd_type              cmd_ff;
   logic [QUEUE_DEPTH-1:0][SW-1:0] rd_ids_ff;
   logic [QUEUE_DEPTH-1:0]         rd_urg_ff;
   logic [FW-1:0]                  rd_fill_ff;
   logic                           rd_vld_ff;
   logic                           rsp_vld_ff, rsp_vld_in;
   btpq_pkg::rsp_type              rsp_ff, rsp_in;

   logic [XW-1:0]                  rd_sel_ext, wr_sel_ext;
   logic [RW-1:0]                  rd_idx, wr_idx;
   logic [FW-1:0]                  fill_cur, urg_cnt, ins_pos, fill_new;
   logic [QUEUE_DEPTH-1:0][SW-1:0] ids_new;
   logic [QUEUE_DEPTH-1:0]         urg_new;
   logic                           out_free, done, wr_en;

   assign rd_sel_ext = XW'(pop_data.queue_sel);
   assign wr_sel_ext = XW'(cmd_ff.queue_sel);
   assign rd_idx     = rd_sel_ext[RW-1:0];
   assign wr_idx     = wr_sel_ext[RW-1:0];

   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign pop      = (state_ff == ST_IDLE) && !fifo_status.empty;
   assign done     = (state_ff == ST_MOD) && out_free;
   assign fill_cur = rd_vld_ff ? rd_fill_ff : '0;

   always_comb begin
      urg_cnt = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if ((FW'(i) < fill_cur) && rd_urg_ff[i]) begin
            urg_cnt = urg_cnt + FW'(1);
         end
      end
      ins_pos = cmd_ff.urgent ? urg_cnt : fill_cur;

      ids_new  = rd_ids_ff;
      urg_new  = rd_urg_ff;
      fill_new = fill_cur;
      wr_en    = 1'b0;
      rsp_in.result_code   = btpq_pkg::RES_FULL;
      rsp_in.served_id     = '0;
      rsp_in.served_urgent = 1'b0;

      if (cmd_ff.func == btpq_pkg::FUNC_ADD) begin
         if (cmd_ff.in_range && (fill_cur < FW'(QUEUE_DEPTH))) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (FW'(i) == ins_pos) begin
                  ids_new[i] = cmd_ff.entry_id[SW-1:0];
                  urg_new[i] = cmd_ff.urgent;
               end else if ((FW'(i) > ins_pos) && (i > 0)) begin
                  ids_new[i] = rd_ids_ff[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                  urg_new[i] = rd_urg_ff[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
               end
            end
            fill_new = fill_cur + FW'(1);
            wr_en    = 1'b1;
            rsp_in.result_code = btpq_pkg::RES_ADDED;
         end
      end else begin
         if (cmd_ff.in_range && (fill_cur != '0)) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (i + 1 < QUEUE_DEPTH) begin
                  ids_new[i] = rd_ids_ff[(i + 1) % QUEUE_DEPTH];
                  urg_new[i] = rd_urg_ff[(i + 1) % QUEUE_DEPTH];
               end
            end
            fill_new = fill_cur - FW'(1);
            wr_en    = 1'b1;
            rsp_in.result_code   = btpq_pkg::RES_SERVED;
            rsp_in.served_id     = btpq_pkg::ENTRY_ID_W'(rd_ids_ff[0]);
            rsp_in.served_urgent = rd_urg_ff[0];
         end else begin
            rsp_in.result_code = btpq_pkg::RES_EMPTY;
         end
      end

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_vld_in = rsp_vld_ff;
      if (done) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         row_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         if (done && wr_en) begin
            row_vld_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff     <= pop_data;
         rd_ids_ff  <= mem_ids[rd_idx];
         rd_urg_ff  <= mem_urg[rd_idx];
         rd_fill_ff <= mem_fill[rd_idx];
         rd_vld_ff  <= row_vld_ff[rd_idx];
      end
      if (done && wr_en) begin
         mem_ids[wr_idx]  <= ids_new;
         mem_urg[wr_idx]  <= urg_new;
         mem_fill[wr_idx] <= fill_new;
      end
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `BTPQ_ASSERT(a_back_pop_idle, clock, reset, pop |-> state_ff == ST_IDLE, "pop outside idle")
   `BTPQ_ASSERT(a_back_fill_bound, clock, reset,
      (state_ff == ST_MOD) |-> (fill_cur <= FW'(QUEUE_DEPTH)), "queue fill beyond depth")
   `BTPQ_ASSERT(a_back_done_result, clock, reset,
      done |=> (rsp_vld_ff && state_ff == ST_IDLE), "finished command without result")

endmodule
`default_nettype wire

[design/banked_two_class_priority_queue.sv]
// An accepted request passes the front register, the command queue, the row read
// registers and the result register. The back part takes no new command until the
// read-modify-write of the addressed queue row (read, then update and write) ends.
// Reset clears the front register, the command queue, the back state machine and
// the per-row valid bits; row contents are not cleared and no clearing pass runs.
// Top level: banked two-class priority queue.
`default_nettype none
module banked_two_class_priority_queue #(
   parameter int NUM_QUEUES  = 32,
   parameter int QUEUE_DEPTH = 5,
   parameter int ID_WIDTH    = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire btpq_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output btpq_pkg::rsp_type       rsp_data
);

   btpq_pkg::fifo_status_type fifo_status;
   btpq_pkg::cmd_type         push_data;
   btpq_pkg::cmd_type         pop_data;
   logic                      push;
   logic                      pop;

   btpq_front #(
      .NUM_QUEUES (NUM_QUEUES),
      .ID_WIDTH   (ID_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .fifo_status (fifo_status),
      .push        (push),
      .push_data   (push_data)
   );

   btpq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   btpq_back #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

[sim/tb_banked_two_class_priority_queue.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the banked two-class priority queue with its own predictor.
module tb_banked_two_class_priority_queue;

   localparam int N_QUEUES = 32;
   localparam int Q_DEPTH  = 5;
   localparam int N_RANDOM = 400;

   typedef struct {
      btpq_pkg::req_type cmd;
      bit                drain;
   } stim_type;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   btpq_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   btpq_pkg::rsp_type rsp_data;

   stim_type          pending_cmds[$];
   stim_type          next_cmd;
   btpq_pkg::rsp_type awaited_rsp[$];
   logic [15:0]       slot_id[N_QUEUES][Q_DEPTH];
   logic              slot_urg[N_QUEUES][Q_DEPTH];
   int unsigned       fill_cnt[N_QUEUES];
   int unsigned       fail_count = 0;
   bit                req_fired  = 1'b0;
   int unsigned       burst_left = 4;
   int unsigned       gap_left   = 0;
   int unsigned       cycle_cnt  = 0;
   int unsigned       stall_run  = 0;
   logic              stall_lvl  = 1'b0;

   banked_two_class_priority_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic btpq_pkg::rsp_type queue_bank_step(btpq_pkg::req_type r);
      btpq_pkg::rsp_type o;
      int unsigned       q;
      int unsigned       n;
      int unsigned       urg_n;
      int unsigned       i;
      o = '0;
      q = r.queue_sel;
      n = fill_cnt[q];
      if (r.func == btpq_pkg::FUNC_ADD) begin
         if (n >= Q_DEPTH) begin
            o.result_code = btpq_pkg::RES_FULL;
         end else begin
            if (r.urgent) begin
               urg_n = 0;
               for (i = 0; i < n; i++) urg_n += slot_urg[q][i];
               for (i = n; i > urg_n; i--) begin
                  slot_id[q][i]  = slot_id[q][i-1];
                  slot_urg[q][i] = slot_urg[q][i-1];
               end
               slot_id[q][urg_n]  = r.entry_id;
               slot_urg[q][urg_n] = 1'b1;
            end else begin
               slot_id[q][n]  = r.entry_id;
               slot_urg[q][n] = 1'b0;
            end
            fill_cnt[q]   = n + 1;
            o.result_code = btpq_pkg::RES_ADDED;
         end
      end else if (n == 0) begin
         o.result_code = btpq_pkg::RES_EMPTY;
      end else begin
         o.result_code   = btpq_pkg::RES_SERVED;
         o.served_id     = slot_id[q][0];
         o.served_urgent = slot_urg[q][0];
         for (i = 0; i + 1 < n; i++) begin
            slot_id[q][i]  = slot_id[q][i+1];
            slot_urg[q][i] = slot_urg[q][i+1];
         end
         fill_cnt[q] = n - 1;
      end
      return o;
   endfunction

   function automatic void push_cmd(logic f, logic [4:0] q, logic [15:0] id, logic u, bit d);
      stim_type s;
      s.cmd.func      = f;
      s.cmd.queue_sel = q;
      s.cmd.entry_id  = id;
      s.cmd.urgent    = u;
      s.drain         = d;
      pending_cmds.insert(pending_cmds.size(), s);
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   // sender: bursts of random length with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         req_fired = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() == 0 ||
                      (pending_cmds[0].drain && awaited_rsp.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            next_cmd = pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_data  <= next_cmd.cmd;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver: cycle through free-flowing, random, heavy and long-run stall phases
   always @(negedge clock) begin
      cycle_cnt++;
      case ((cycle_cnt / 150) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_run == 0) begin
               stall_run = $urandom_range(1, 12);
               stall_lvl = ~stall_lvl;
            end
            stall_run--;
            rsp_stall <= stall_lvl;
         end
      endcase
   end

   always @(posedge clock) begin
      btpq_pkg::rsp_type want;
      if (!reset && req_valid && !req_stall) begin
         awaited_rsp.insert(awaited_rsp.size(), queue_bank_step(req_data));
         req_fired = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected response transaction",
                            16'(rsp_data.result_code), 16'h0000);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.result_code !== want.result_code)
               report_mismatch("result_code", 16'(rsp_data.result_code),
                               16'(want.result_code));
            if (rsp_data.served_id !== want.served_id)
               report_mismatch("served_id", rsp_data.served_id, want.served_id);
            if (rsp_data.served_urgent !== want.served_urgent)
               report_mismatch("served_urgent", 16'(rsp_data.served_urgent),
                               16'(want.served_urgent));
         end
      end
   end

   initial begin
      int unsigned k;
      int unsigned q;
      bit          fill_phase;
      for (k = 0; k < N_QUEUES; k++) fill_cnt[k] = 0;

      // class ordering, full and empty on one queue
      push_cmd(btpq_pkg::FUNC_ADD, 5'd0, 16'h0000, 1'b0, 1'b0);
      push_cmd(btpq_pkg::FUNC_ADD, 5'd0, 16'hFFFF, 1'b1, 1'b0);
      push_cmd(btpq_pkg::FUNC_ADD, 5'd0, 16'h1234, 1'b0, 1'b0);
      push_cmd(btpq_pkg::FUNC_ADD, 5'd0, 16'h8001, 1'b1, 1'b0);
      push_cmd(btpq_pkg::FUNC_ADD, 5'd0, 16'h7FFE, 1'b0, 1'b0);
      push_cmd(btpq_pkg::FUNC_ADD, 5'd0, 16'hAAAA, 1'b1, 1'b0);
      push_cmd(btpq_pkg::FUNC_ADD, 5'd0, 16'h5555, 1'b0, 1'b0);
      for (k = 0; k < 6; k++) push_cmd(btpq_pkg::FUNC_TAKE, 5'd0, 16'h0000, 1'b0, 1'b0);
      // top queue, take with ignored fields set
      push_cmd(btpq_pkg::FUNC_ADD, 5'd31, 16'h5555, 1'b1, 1'b0);
      push_cmd(btpq_pkg::FUNC_ADD, 5'd31, 16'hAAAA, 1'b1, 1'b0);
      push_cmd(btpq_pkg::FUNC_TAKE, 5'd31, 16'hFFFF, 1'b1, 1'b0);
      push_cmd(btpq_pkg::FUNC_TAKE, 5'd31, 16'h0000, 1'b0, 1'b0);
      push_cmd(btpq_pkg::FUNC_TAKE, 5'd31, 16'hFFFF, 1'b1, 1'b0);
      push_cmd(btpq_pkg::FUNC_TAKE, 5'd16, 16'h0F0F, 1'b0, 1'b0);

      fill_phase = 1'b1;
      for (k = 0; k < N_RANDOM; k++) begin
         if (k % 40 == 0) fill_phase = ~fill_phase;
         q = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 31);
         push_cmd(($urandom_range(0, 9) < 7) ?
                     (fill_phase ? btpq_pkg::FUNC_ADD : btpq_pkg::FUNC_TAKE) :
                     (fill_phase ? btpq_pkg::FUNC_TAKE : btpq_pkg::FUNC_ADD),
                  5'(q), 16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                  (k == 0 || k == 150 || k == 300));
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_cmds.size() != 0 || req_valid) @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (awaited_rsp.size() != 0 || fail_count != 0) begin
         $display("banked_two_class_priority_queue test failed");
      end else begin
         $display("banked_two_class_priority_queue test passed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("banked_two_class_priority_queue test failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/btpq_pkg.sv
design/btpq_fifo.sv
design/btpq_front.sv
design/btpq_back.sv
design/banked_two_class_priority_queue.sv
sim/tb_banked_two_class_priority_queue.sv
